FILE: hdl/eul_pkg.sv
// ----------------------------------------------------------------------------
// eul_pkg
// Shared widths, constants and types of the Euler XYZ rotation matrix core.
// ----------------------------------------------------------------------------
package eul_pkg;

    // Field widths
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = FRAC_BITS + 2;
    localparam int PHI_BITS   = ANGLE_BITS - 2;

    // Internal Q31 trig datapath
    localparam int Q_BITS   = 31;
    localparam int ACC_BITS = Q_BITS + 1;
    localparam int DIV_BITS = 8;
    localparam int RCP_BITS = 31;
    localparam int C_BITS   = 43;
    localparam logic [C_BITS-1:0] TWO_PI_Q40 = 43'h6487ED5110B;

    // Horner steps: cosine runs all of them, sine all but the last
    localparam int STEPS     = 7;
    localparam int SIN_STEPS = 6;

    // Pipeline depth: fold, square, three stages a step, final product, round
    localparam int LANE_STAGES = 2 + 3 * STEPS + 2;
    localparam int COMP_STAGES = 4;
    localparam int PIPE_DEPTH  = LANE_STAGES + COMP_STAGES;

    // Horner divisors n*(n-1) and reciprocals floor(2^31 / d)
    localparam logic [DIV_BITS-1:0] SIN_DIV [SIN_STEPS] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [DIV_BITS-1:0] COS_DIV [STEPS] =
        '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [RCP_BITS-1:0] SIN_RCP [SIN_STEPS] = '{
        RCP_BITS'((64'd1 << 31) / 64'd156), RCP_BITS'((64'd1 << 31) / 64'd110),
        RCP_BITS'((64'd1 << 31) / 64'd72),  RCP_BITS'((64'd1 << 31) / 64'd42),
        RCP_BITS'((64'd1 << 31) / 64'd20),  RCP_BITS'((64'd1 << 31) / 64'd6)};
    localparam logic [RCP_BITS-1:0] COS_RCP [STEPS] = '{
        RCP_BITS'((64'd1 << 31) / 64'd182), RCP_BITS'((64'd1 << 31) / 64'd132),
        RCP_BITS'((64'd1 << 31) / 64'd90),  RCP_BITS'((64'd1 << 31) / 64'd56),
        RCP_BITS'((64'd1 << 31) / 64'd30),  RCP_BITS'((64'd1 << 31) / 64'd12),
        RCP_BITS'((64'd1 << 31) / 64'd2)};

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef logic signed [OUT_BITS-1:0] fix_t;

    localparam fix_t ONE_F = fix_t'(64'd1 << FRAC_BITS);

    // Sine/cosine pair from one trig lane
    typedef struct packed {
        fix_t s;
        fix_t c;
    } sc_t;

endpackage

FILE: hdl/euler_xyz_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_xyz_rotation_matrix_core
// Rotation matrix Rx*Ry*Rz from three binary angles, nine Q1.16 entries.
// ----------------------------------------------------------------------------
// Takes one angle triple per clock while in_stall is low and returns one
// matrix per triple, in order, holding it while out_stall is high.
// Three trig lanes (one per angle) run a 25-stage pipeline of Horner steps,
// three stages per step for the 7-step cosine series, followed by a 4-stage
// matrix merge. Each stage holds its item only while it cannot move on, so
// bubbles are squeezed out under out_stall and in_stall rises only once all
// 29 stages hold items.
module euler_xyz_rotation_matrix_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [eul_pkg::ANGLE_BITS-1:0]      angle_x,
    input  logic [eul_pkg::ANGLE_BITS-1:0]      angle_y,
    input  logic [eul_pkg::ANGLE_BITS-1:0]      angle_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output eul_pkg::fix_t                       rot_r0c0,
    output eul_pkg::fix_t                       rot_r0c1,
    output eul_pkg::fix_t                       rot_r0c2,
    output eul_pkg::fix_t                       rot_r1c0,
    output eul_pkg::fix_t                       rot_r1c1,
    output eul_pkg::fix_t                       rot_r1c2,
    output eul_pkg::fix_t                       rot_r2c0,
    output eul_pkg::fix_t                       rot_r2c1,
    output eul_pkg::fix_t                       rot_r2c2
);

    localparam int N  = eul_pkg::PIPE_DEPTH;
    localparam int LS = eul_pkg::LANE_STAGES;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N-1:0] en;

    // Stage enable: free unless stalled and this stage and every later stage are full
    for (genvar i = 0; i < N; i++)
    begin : g_en
        assign en[i] = !out_stall || !(&vld_reg[N-1:i]);
    end

    // Valid tracking
    always_comb
    begin
        vld_next = (en & {vld_reg[N-2:0], in_valid}) | (~en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[N-1];

    // Trig lanes
    eul_pkg::sc_t sc_x;
    eul_pkg::sc_t sc_y;
    eul_pkg::sc_t sc_z;

    eul_sincos u_lane_x (
        .clk   (clk),
        .en    (en[LS-1:0]),
        .angle (angle_x),
        .sc    (sc_x)
    );

    eul_sincos u_lane_y (
        .clk   (clk),
        .en    (en[LS-1:0]),
        .angle (angle_y),
        .sc    (sc_y)
    );

    eul_sincos u_lane_z (
        .clk   (clk),
        .en    (en[LS-1:0]),
        .angle (angle_z),
        .sc    (sc_z)
    );

    // Matrix merge
    eul_pkg::fix_t ent [9];

    eul_compose u_compose (
        .clk  (clk),
        .en   (en[N-1:LS]),
        .sc_x (sc_x),
        .sc_y (sc_y),
        .sc_z (sc_z),
        .ent  (ent)
    );

    assign rot_r0c0 = ent[0];
    assign rot_r0c1 = ent[1];
    assign rot_r0c2 = ent[2];
    assign rot_r1c0 = ent[3];
    assign rot_r1c1 = ent[4];
    assign rot_r1c2 = ent[5];
    assign rot_r2c0 = ent[6];
    assign rot_r2c1 = ent[7];
    assign rot_r2c2 = ent[8];

    // Checks
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg) && out_stall)
        else $error("input stalled with a bubble in the pipeline");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] && !en[1] |=> vld_reg[1])
        else $error("held stage lost its item");

    a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rot_r1c1 <= eul_pkg::ONE_F && rot_r1c1 >= -eul_pkg::ONE_F)
        else $error("matrix entry outside +/-1.0");

endmodule

FILE: hdl/eul_sincos.sv
// ----------------------------------------------------------------------------
// eul_sincos
// One trig lane: octant fold, Q31 Taylor series by pipelined Horner steps,
// rounding to Q1.F and quadrant sign.
// ----------------------------------------------------------------------------
module eul_sincos (
    input  logic                                 clk,
    input  logic [eul_pkg::LANE_STAGES-1:0]      en,
    input  logic [eul_pkg::ANGLE_BITS-1:0]       angle,
    output eul_pkg::sc_t                         sc
);

    localparam int Q  = eul_pkg::Q_BITS;
    localparam int AW = eul_pkg::ACC_BITS;
    localparam int PW = eul_pkg::PHI_BITS;
    localparam int TW = eul_pkg::PHI_BITS + eul_pkg::C_BITS;
    localparam int F  = eul_pkg::FRAC_BITS;
    localparam int RW = Q + eul_pkg::DIV_BITS;
    localparam int ST = eul_pkg::STEPS;
    localparam int LS = eul_pkg::LANE_STAGES;

    typedef struct packed {
        logic [Q-1:0]  t2;
        logic [Q-1:0]  th;
        logic [1:0]    quad;
        logic          swap;
        logic [AW-1:0] sa;
        logic [AW-1:0] ca;
    } ctx_t;

    // Finish one Horner step: exact quotient from reciprocal estimate, then 1 - q
    function automatic logic [AW-1:0] horner_fin(
        input logic [Q-1:0]                    x,
        input logic [2*Q-1:0]                  m,
        input logic [eul_pkg::DIV_BITS-1:0]    d
    );
        logic [Q-1:0]  q0;
        logic [RW-1:0] rem;
        q0  = m[2*Q-1:Q];
        rem = RW'(x) - RW'(q0) * RW'(d);
        if (rem >= RW'(d))
            q0 = q0 + 1'b1;
        return (AW'(1) << Q) - AW'(q0);
    endfunction

    // Stage 0: fold into first octant, convert to radians
    logic [1:0]    quad_c;
    logic [PW-1:0] r_c;
    logic [PW:0]   mir_c;
    logic          swap_c;
    logic [PW-1:0] phi_c;
    logic [TW-1:0] thp_c;
    logic [Q-1:0]  th0_reg;
    logic [1:0]    quad0_reg;
    logic          swap0_reg;

    always_comb
    begin
        quad_c = angle[eul_pkg::ANGLE_BITS-1 -: 2];
        r_c    = angle[PW-1:0];
        swap_c = r_c > (PW'(1) << (PW - 1));
        mir_c  = ((PW + 1)'(1) << PW) - (PW + 1)'(r_c);
        phi_c  = swap_c ? mir_c[PW-1:0] : r_c;
        thp_c  = TW'(phi_c) * TW'(eul_pkg::TWO_PI_Q40)
                 + (TW'(1) << (eul_pkg::ANGLE_BITS + 8));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            th0_reg   <= Q'(thp_c >> (eul_pkg::ANGLE_BITS + 9));
            quad0_reg <= quad_c;
            swap0_reg <= swap_c;
        end
    end

    // Stage 1: theta squared in Q31
    logic [2*Q-1:0] sq_c;
    ctx_t           ctx_reg [ST+1];

    assign sq_c = (2*Q)'(th0_reg) * (2*Q)'(th0_reg) + ((2*Q)'(1) << 30);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ctx_reg[0].t2   <= sq_c[2*Q-1:Q];
            ctx_reg[0].th   <= th0_reg;
            ctx_reg[0].quad <= quad0_reg;
            ctx_reg[0].swap <= swap0_reg;
            ctx_reg[0].sa   <= AW'(1) << Q;
            ctx_reg[0].ca   <= AW'(1) << Q;
        end
    end

    // Horner steps: multiply, reciprocal multiply, correct
    for (genvar k = 0; k < ST; k++)
    begin : g_step
        ctx_t           ctxa_reg;
        ctx_t           ctxb_reg;
        logic [2*Q:0]   pc_c;
        logic [Q-1:0]   xca_reg;
        logic [Q-1:0]   xcb_reg;
        logic [2*Q-1:0] mcb_reg;
        logic [AW-1:0]  sa_new;

        assign pc_c = (2*Q+1)'(ctx_reg[k].t2) * (2*Q+1)'(ctx_reg[k].ca);

        always_ff @(posedge clk)
        begin
            if (en[2+3*k])
            begin
                ctxa_reg <= ctx_reg[k];
                xca_reg  <= pc_c[2*Q-1:Q];
            end
            if (en[3+3*k])
            begin
                ctxb_reg <= ctxa_reg;
                xcb_reg  <= xca_reg;
                mcb_reg  <= (2*Q)'(xca_reg) * (2*Q)'(eul_pkg::COS_RCP[k]);
            end
            if (en[4+3*k])
            begin
                ctx_reg[k+1] <= '{
                    t2:   ctxb_reg.t2,
                    th:   ctxb_reg.th,
                    quad: ctxb_reg.quad,
                    swap: ctxb_reg.swap,
                    sa:   sa_new,
                    ca:   horner_fin(xcb_reg, mcb_reg, eul_pkg::COS_DIV[k])
                };
            end
        end

        if (k < eul_pkg::SIN_STEPS)
        begin : g_sin
            logic [2*Q:0]   ps_c;
            logic [Q-1:0]   xsa_reg;
            logic [Q-1:0]   xsb_reg;
            logic [2*Q-1:0] msb_reg;

            assign ps_c   = (2*Q+1)'(ctx_reg[k].t2) * (2*Q+1)'(ctx_reg[k].sa);
            assign sa_new = horner_fin(xsb_reg, msb_reg, eul_pkg::SIN_DIV[k]);

            always_ff @(posedge clk)
            begin
                if (en[2+3*k])
                    xsa_reg <= ps_c[2*Q-1:Q];
                if (en[3+3*k])
                begin
                    xsb_reg <= xsa_reg;
                    msb_reg <= (2*Q)'(xsa_reg) * (2*Q)'(eul_pkg::SIN_RCP[k]);
                end
            end
        end
        else
        begin : g_sin_hold
            assign sa_new = ctxb_reg.sa;
        end
    end

    // Final sine product theta * series
    logic [2*Q:0]  sp_c;
    logic [Q-1:0]  sm_reg;
    logic [AW-1:0] cf_reg;
    logic [1:0]    quadf_reg;
    logic          swapf_reg;

    assign sp_c = (2*Q+1)'(ctx_reg[ST].th) * (2*Q+1)'(ctx_reg[ST].sa);

    always_ff @(posedge clk)
    begin
        if (en[LS-2])
        begin
            sm_reg    <= sp_c[2*Q-1:Q];
            cf_reg    <= ctx_reg[ST].ca;
            quadf_reg <= ctx_reg[ST].quad;
            swapf_reg <= ctx_reg[ST].swap;
        end
    end

    // Round to Q1.F, undo octant swap, apply quadrant signs
    logic [AW:0]  sr_c;
    logic [AW:0]  cr_c;
    logic [F:0]   smag_c;
    logic [F:0]   cmag_c;
    eul_pkg::fix_t rs_c;
    eul_pkg::fix_t rc_c;
    eul_pkg::sc_t  sc_c;
    eul_pkg::sc_t  sc_reg;

    always_comb
    begin
        sr_c   = ((AW + 1)'(sm_reg) + ((AW + 1)'(1) << (30 - F))) >> (31 - F);
        cr_c   = ((AW + 1)'(cf_reg) + ((AW + 1)'(1) << (30 - F))) >> (31 - F);
        smag_c = sr_c[F:0];
        cmag_c = cr_c[F:0];
        rs_c   = swapf_reg ? eul_pkg::fix_t'({1'b0, cmag_c})
                           : eul_pkg::fix_t'({1'b0, smag_c});
        rc_c   = swapf_reg ? eul_pkg::fix_t'({1'b0, smag_c})
                           : eul_pkg::fix_t'({1'b0, cmag_c});
        case (quadf_reg)
            eul_pkg::QUAD_0: begin sc_c.s = rs_c;  sc_c.c = rc_c;  end
            eul_pkg::QUAD_1: begin sc_c.s = rc_c;  sc_c.c = -rs_c; end
            eul_pkg::QUAD_2: begin sc_c.s = -rs_c; sc_c.c = -rc_c; end
            default:         begin sc_c.s = -rc_c; sc_c.c = rs_c;  end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[LS-1])
            sc_reg <= sc_c;
    end

    assign sc = sc_reg;

endmodule

FILE: hdl/eul_compose.sv
// ----------------------------------------------------------------------------
// eul_compose
// Merge stage: combines the three lane results into Rx*Ry*Rz with exact
// products, one rounding half away from zero and saturation to +/-1.0.
// ----------------------------------------------------------------------------
module eul_compose (
    input  logic                               clk,
    input  logic [eul_pkg::COMP_STAGES-1:0]    en,
    input  eul_pkg::sc_t                       sc_x,
    input  eul_pkg::sc_t                       sc_y,
    input  eul_pkg::sc_t                       sc_z,
    output eul_pkg::fix_t                      ent [9]
);

    localparam int F  = eul_pkg::FRAC_BITS;
    localparam int PB = 2 * F + 2;
    localparam int WB = 3 * F + 2;
    localparam int SB = 3 * F + 3;

    // Round Q.3F-scaled sum to Q.F, half away from zero, clamp to one
    function automatic eul_pkg::fix_t round_sat(input logic signed [SB-1:0] e);
        logic          neg;
        logic [SB-1:0] mag;
        logic [SB-1:0] rnd;
        logic [F:0]    m;
        neg = e[SB-1];
        mag = neg ? SB'(-e) : SB'(e);
        rnd = (mag + (SB'(1) << (2 * F - 1))) >> (2 * F);
        if (rnd > (SB'(1) << F))
            m = (F + 1)'(1) << F;
        else
            m = rnd[F:0];
        return neg ? -eul_pkg::fix_t'({1'b0, m}) : eul_pkg::fix_t'({1'b0, m});
    endfunction

    // Stage 0: Rx*Ry in Q.2F
    logic signed [PB-1:0] pxy_reg [3][3];
    eul_pkg::sc_t         z0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pxy_reg[0][0] <= PB'(sc_y.c) <<< F;
            pxy_reg[0][1] <= '0;
            pxy_reg[0][2] <= PB'(sc_y.s) <<< F;
            pxy_reg[1][0] <= PB'(sc_x.s) * PB'(sc_y.s);
            pxy_reg[1][1] <= PB'(sc_x.c) <<< F;
            pxy_reg[1][2] <= -(PB'(sc_x.s) * PB'(sc_y.c));
            pxy_reg[2][0] <= -(PB'(sc_x.c) * PB'(sc_y.s));
            pxy_reg[2][1] <= PB'(sc_x.s) <<< F;
            pxy_reg[2][2] <= PB'(sc_x.c) * PB'(sc_y.c);
            z0_reg        <= sc_z;
        end
    end

    // Stage 1: products with Rz in Q.3F
    logic signed [WB-1:0] tm_reg [3][4];
    logic signed [WB-1:0] c2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                tm_reg[i][0] <= WB'(pxy_reg[i][0]) * WB'(z0_reg.c);
                tm_reg[i][1] <= WB'(pxy_reg[i][1]) * WB'(z0_reg.s);
                tm_reg[i][2] <= WB'(pxy_reg[i][0]) * WB'(z0_reg.s);
                tm_reg[i][3] <= WB'(pxy_reg[i][1]) * WB'(z0_reg.c);
                c2_reg[i]    <= WB'(pxy_reg[i][2]) <<< F;
            end
        end
    end

    // Stage 2: column sums
    logic signed [SB-1:0] sum_reg [9];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[3*i]   <= SB'(tm_reg[i][0]) + SB'(tm_reg[i][1]);
                sum_reg[3*i+1] <= SB'(tm_reg[i][3]) - SB'(tm_reg[i][2]);
                sum_reg[3*i+2] <= SB'(c2_reg[i]);
            end
        end
    end

    // Stage 3: round and saturate into the output register
    eul_pkg::fix_t ent_reg [9];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int j = 0; j < 9; j++)
                ent_reg[j] <= round_sat(sum_reg[j]);
        end
    end

    assign ent = ent_reg;

endmodule

FILE: tb/euler_xyz_rotation_matrix_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_xyz_rotation_matrix_core_tb
// Self-checking bench for the Euler XYZ rotation matrix core.
// ----------------------------------------------------------------------------
// Sends angle triples through the valid/stall input and checks each matrix
// against a fixed-point predictor of Rx*Ry*Rz: table-driven directed items,
// then random triples biased to quadrant and octant edges, over phases of
// sender idling and receiver stalling.
module euler_xyz_rotation_matrix_core_tb;

    typedef eul_pkg::fix_t [8:0] mat_t;
    typedef logic [eul_pkg::ANGLE_BITS-1:0] ang_t;

    typedef struct {
        ang_t ax;
        ang_t ay;
        ang_t az;
        bit   typed;
        mat_t want;
    } stim_row_t;

    localparam int QUARTER = 1 << (eul_pkg::ANGLE_BITS - 2);

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    ang_t angle_x, angle_y, angle_z;
    logic out_valid;
    logic out_stall;
    eul_pkg::fix_t rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2;
    eul_pkg::fix_t rot_r2c0, rot_r2c1, rot_r2c2;

    mat_t matrix_fifo[$];
    int   mismatches;
    int   send_idle_pct;
    int   recv_stall_pct;

    euler_xyz_rotation_matrix_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .rot_r0c0(rot_r0c0), .rot_r0c1(rot_r0c1), .rot_r0c2(rot_r0c2),
        .rot_r1c0(rot_r1c0), .rot_r1c1(rot_r1c1), .rot_r1c2(rot_r1c2),
        .rot_r2c0(rot_r2c0), .rot_r2c1(rot_r2c1), .rot_r2c2(rot_r2c2)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sine and cosine in Q1.16 via octant fold and truncated Horner series
    task automatic sin_cos_fix(input ang_t a, output longint s, output longint c);
        longint unsigned r, phi, th, t2, sa, ca, n;
        longint sv, cv, rs, rc;
        bit mirror;
        logic [1:0] quad;
        quad   = a[eul_pkg::ANGLE_BITS-1 -: 2];
        r      = a & (QUARTER - 1);
        mirror = r > (QUARTER / 2);
        phi    = mirror ? QUARTER - r : r;
        th     = (phi * 64'h6487ED5110B + (64'd1 << (eul_pkg::ANGLE_BITS + 8)))
                 >> (eul_pkg::ANGLE_BITS + 9);
        t2     = (th * th + (64'd1 << 30)) >> 31;
        sa     = 64'd1 << 31;
        ca     = 64'd1 << 31;
        for (n = 13; n >= 3; n -= 2)
            sa = (64'd1 << 31) - ((t2 * sa) >> 31) / (n * (n - 1));
        for (n = 14; n >= 2; n -= 2)
            ca = (64'd1 << 31) - ((t2 * ca) >> 31) / (n * (n - 1));
        sv = longint'(((((th * sa) >> 31) + (64'd1 << 14)) >> 15));
        cv = longint'(((ca + (64'd1 << 14)) >> 15));
        rs = mirror ? cv : sv;
        rc = mirror ? sv : cv;
        case (quad)
            eul_pkg::QUAD_0: begin s = rs;  c = rc;  end
            eul_pkg::QUAD_1: begin s = rc;  c = -rs; end
            eul_pkg::QUAD_2: begin s = -rs; c = -rc; end
            default:         begin s = -rc; c = rs;  end
        endcase
    endtask

    // Rx*Ry*Rz with exact products, one round half away from zero, saturate
    task automatic predict_matrix(input ang_t ax, ay, az, output mat_t m);
        longint sx, cx, sy, cy, sz, cz, acc, mag;
        longint rx[3][3], ry[3][3], rz[3][3], pxy[3][3];
        longint one;
        one = longint'(1) << eul_pkg::FRAC_BITS;
        sin_cos_fix(ax, sx, cx);
        sin_cos_fix(ay, sy, cy);
        sin_cos_fix(az, sz, cz);
        rx = '{'{one, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        ry = '{'{cy, 0, sy}, '{0, one, 0}, '{-sy, 0, cy}};
        rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, one}};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                pxy[i][j] = rx[i][0] * ry[0][j] + rx[i][1] * ry[1][j] + rx[i][2] * ry[2][j];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = pxy[i][0] * rz[0][j] + pxy[i][1] * rz[1][j] + pxy[i][2] * rz[2][j];
                mag = ((acc < 0 ? -acc : acc) + (longint'(1) << 31)) >>> 32;
                if (mag > one)
                    mag = one;
                m[i * 3 + j] = eul_pkg::fix_t'(acc < 0 ? -mag : mag);
            end
    endtask

    // One input transfer; idles first at the phase's rate
    task automatic send_angles(input ang_t ax, ay, az, input bit typed, input mat_t want);
        mat_t m;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        angle_x  <= ax;
        angle_y  <= ay;
        angle_z  <= az;
        do
            @(posedge clk);
        while (in_stall);
        if (typed)
            m = want;
        else
            predict_matrix(ax, ay, az, m);
        matrix_fifo.push_back(m);
    endtask

    // Random angle, often on a quadrant or octant edge
    function automatic ang_t pick_angle();
        int edges[6] = '{0, 1, QUARTER / 2 - 1, QUARTER / 2, QUARTER / 2 + 1, QUARTER - 1};
        if ($urandom_range(0, 99) < 70)
            return ang_t'($urandom);
        return ang_t'(($urandom_range(0, 3) * QUARTER) + edges[$urandom_range(0, 5)]);
    endfunction

    task automatic drain_and_pause();
        in_valid <= 1'b0;
        while (matrix_fifo.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Result check against the oldest expected matrix
    always @(posedge clk)
    begin
        mat_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {rot_r2c2, rot_r2c1, rot_r2c0, rot_r1c2, rot_r1c1, rot_r1c0,
                   rot_r0c2, rot_r0c1, rot_r0c0};
            if (matrix_fifo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected matrix transfer at %0t", $realtime);
            end
            else
            begin
                want = matrix_fifo.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== want[k])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("r%0dc%0d: expected %0d got %0d", k / 3, k % 3,
                                     $signed(want[k]), $signed(got[k]));
                    end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        stim_row_t table_rows[$];
        mat_t ident, none;
        int phase_send[4] = '{0, 48, 0, 26};
        int phase_recv[4] = '{0, 0, 48, 26};
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        angle_x  = '0;
        angle_y  = '0;
        angle_z  = '0;
        none     = '0;
        ident    = '0;
        ident[0] = eul_pkg::ONE_F;
        ident[4] = eul_pkg::ONE_F;
        ident[8] = eul_pkg::ONE_F;

        // Directed rows: zero angles give the identity, the rest are predicted
        table_rows = '{
            '{16'h0000, 16'h0000, 16'h0000, 1'b1, ident},
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, none},
            '{16'h4000, 16'h0000, 16'h0000, 1'b0, none},
            '{16'h0000, 16'h4000, 16'h0000, 1'b0, none},
            '{16'h0000, 16'h0000, 16'h4000, 1'b0, none},
            '{16'h8000, 16'h8000, 16'h8000, 1'b0, none},
            '{16'hC000, 16'hC000, 16'hC000, 1'b0, none},
            '{16'h2000, 16'h2000, 16'h2000, 1'b0, none},
            '{16'h1FFF, 16'h2001, 16'h3FFF, 1'b0, none},
            '{16'h2001, 16'h1FFF, 16'h0001, 1'b0, none},
            '{16'h6000, 16'hA000, 16'hE000, 1'b0, none},
            '{16'h4001, 16'h7FFF, 16'hBFFF, 1'b0, none},
            '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, none},
            '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, none},
            '{16'h2000, 16'h6000, 16'hA000, 1'b0, none},
            '{16'h0001, 16'hFFFF, 16'h8001, 1'b0, none}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_angles(table_rows[i].ax, table_rows[i].ay, table_rows[i].az,
                        table_rows[i].typed, table_rows[i].want);
        drain_and_pause();

        // Random phases over the idle/stall mix, draining between them
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            for (int n = 0; n < 285; n++)
                send_angles(pick_angle(), pick_angle(), pick_angle(), 1'b0, none);
            drain_and_pause();
        end

        recv_stall_pct = 0;
        repeat (40) @(posedge clk);
        if (mismatches == 0 && matrix_fifo.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: euler_xyz_rotation_matrix_core.f
hdl/eul_pkg.sv
hdl/eul_sincos.sv
hdl/eul_compose.sv
hdl/euler_xyz_rotation_matrix_core.sv
tb/euler_xyz_rotation_matrix_core_tb.sv
